[rtl/etl_pkg.sv]
package etl_pkg;

	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;
	localparam logic [31:0] TICK_MAX   = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		OP_ARM_IN     = 4'd0,
		OP_SIGNAL     = 4'd1,
		OP_CHK_IN     = 4'd2,
		OP_CLR_IN     = 4'd3,
		OP_SET_TMR    = 4'd4,
		OP_CHK_TMR    = 4'd5,
		OP_CLR_TMR    = 4'd6,
		OP_UNTIL_TMR  = 4'd7,
		OP_UNTIL_NEXT = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCAN_A = 4'b0100,
		ST_SCAN_B = 4'b1000
	} state_t;

	typedef enum logic {
		DM_DIST = 1'b0,
		DM_ADD  = 1'b1
	} dmode_t;

	typedef struct packed {
		logic load;
		logic disarm;
	} tmr_ctl_t;

endpackage

[rtl/etl_dist_unit.sv]
module etl_dist_unit (
	input  etl_pkg::dmode_t mode,
	input  logic [31:0]     a,
	input  logic [31:0]     b,
	output logic [31:0]     res,
	output logic            le_imax,
	output logic            lt_imax
);

	logic [31:0] y;
	logic        cin;

	// In distance mode the result is b - a when a <= b, and one less on wrap.
	always_comb begin
		if (mode == etl_pkg::DM_DIST) begin
			y   = ~a;
			cin = (a <= b);
		end else begin
			y   = a;
			cin = 1'b0;
		end
		res     = b + y + {31'b0, cin};
		le_imax = (res <= etl_pkg::HALF_RANGE);
		lt_imax = (res < etl_pkg::HALF_RANGE);
	end

endmodule

[rtl/etl_tmr_bank.sv]
module etl_tmr_bank #(
	parameter int NUM_TIMERS = 8,
	parameter int TW         = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  etl_pkg::tmr_ctl_t ctl,
	input  logic [TW-1:0]     sel,
	input  logic [31:0]       wr_deadline,
	output logic [31:0]       rd_deadline,
	output logic              rd_armed
);

	logic [31:0]           deadline_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] armed_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			deadline_q[sel] <= wr_deadline;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (ctl.load) begin
			armed_q[sel] <= 1'b1;
		end else if (ctl.disarm) begin
			armed_q[sel] <= 1'b0;
		end
	end

	assign rd_deadline = deadline_q[sel];
	assign rd_armed    = armed_q[sel];

endmodule

[rtl/event_timer_latch_unit.sv]
// Channel   Ports                                 Handshake
// command   op, index, time_now, timeout          taken when start is high and busy is low
// result    hit, value                            shown for one cycle while done is high
//
// A check, set, clear or arm item passes through ST_EXEC and raises done as it leaves.
// Ticks until a timer scans that timer in ST_SCAN_A and, when it is armed and not yet
// due, in ST_SCAN_B; an index past the last timer ends in ST_EXEC. Ticks until next,
// unless an input is latched, scans every timer the same way through the shared
// subtract and compare unit. Reset disarms every timer and clears the
// input latch. The result cannot be held off and is lost if not taken.
module event_timer_latch_unit #(
	parameter int NUM_TIMERS = 8,
	parameter int NUM_INPUTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [3:0]  op,
	input  logic [2:0]  index,
	input  logic [31:0] time_now,
	input  logic [30:0] timeout,
	output logic        busy,
	output logic        done,
	output logic        hit,
	output logic [31:0] value
);

	localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [TW-1:0] LAST = TW'(NUM_TIMERS - 1);

	etl_pkg::state_t state_q;
	etl_pkg::op_t    op_q;
	logic [2:0]      idx_q;
	logic [31:0]     now_q;
	logic [30:0]     tmo_q;
	logic [TW-1:0]   cnt_q;
	logic            single_q;
	logic [31:0]     min_q;

	logic [NUM_INPUTS-1:0] armed_in_q;
	logic [NUM_INPUTS-1:0] latched_q;
	logic [31:0]           stamp_q;

	logic        done_q;
	logic        hit_q;
	logic [31:0] value_q;

	logic              in_ok;
	logic              tm_ok;
	logic [NUM_INPUTS-1:0] in_bit;
	etl_pkg::dmode_t   dmode;
	logic [31:0]       da;
	logic [31:0]       db;
	logic [31:0]       dres;
	logic              le_imax;
	logic              lt_imax;
	etl_pkg::tmr_ctl_t tctl;
	logic [31:0]       rd_deadline;
	logic              rd_armed;
	logic [31:0]       min_nxt;
	logic              scan_end;

	assign in_ok  = (32'(idx_q) < NUM_INPUTS);
	assign tm_ok  = (32'(idx_q) < NUM_TIMERS);
	assign in_bit = in_ok ? (NUM_INPUTS'(1) << idx_q) : '0;

	always_comb begin
		dmode = etl_pkg::DM_DIST;
		da    = rd_deadline;
		db    = now_q;
		if (state_q == etl_pkg::ST_EXEC) begin
			if (op_q == etl_pkg::OP_CHK_IN) begin
				da = stamp_q;
			end else if (op_q == etl_pkg::OP_SET_TMR) begin
				dmode = etl_pkg::DM_ADD;
				da    = {1'b0, tmo_q};
			end
		end else if (state_q == etl_pkg::ST_SCAN_B) begin
			da = now_q;
			db = rd_deadline;
		end
	end

	etl_dist_unit u_dist (
		.mode    (dmode),
		.a       (da),
		.b       (db),
		.res     (dres),
		.le_imax (le_imax),
		.lt_imax (lt_imax)
	);

	always_comb begin
		tctl = '0;
		if (state_q == etl_pkg::ST_EXEC && tm_ok) begin
			if (op_q == etl_pkg::OP_SET_TMR) begin
				tctl.load = 1'b1;
			end else if (op_q == etl_pkg::OP_CLR_TMR) begin
				tctl.disarm = 1'b1;
			end else if (op_q == etl_pkg::OP_CHK_TMR) begin
				tctl.disarm = rd_armed & lt_imax;
			end
		end
	end

	etl_tmr_bank #(
		.NUM_TIMERS (NUM_TIMERS),
		.TW         (TW)
	) u_tmr_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (tctl),
		.sel         (cnt_q),
		.wr_deadline (dres),
		.rd_deadline (rd_deadline),
		.rd_armed    (rd_armed)
	);

	always_comb begin
		min_nxt = min_q;
		if (state_q == etl_pkg::ST_SCAN_A) begin
			if (rd_armed && le_imax) begin
				min_nxt = '0;
			end
		end else if (state_q == etl_pkg::ST_SCAN_B) begin
			if (dres < min_q) begin
				min_nxt = dres;
			end
		end
		scan_end = single_q || (cnt_q == LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= etl_pkg::ST_IDLE;
			done_q     <= 1'b0;
			armed_in_q <= '0;
			latched_q  <= '0;
			stamp_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				etl_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= etl_pkg::ST_EXEC;
					end
				end
				etl_pkg::ST_EXEC: begin
					state_q <= etl_pkg::ST_IDLE;
					done_q  <= 1'b1;
					unique case (op_q)
						etl_pkg::OP_ARM_IN: begin
							armed_in_q <= armed_in_q | in_bit;
						end
						etl_pkg::OP_SIGNAL: begin
							if (latched_q == '0 && (armed_in_q & in_bit) != '0) begin
								stamp_q   <= now_q;
								latched_q <= in_bit;
							end
						end
						etl_pkg::OP_CHK_IN: begin
							if ((latched_q & in_bit) != '0) begin
								latched_q <= '0;
							end
						end
						etl_pkg::OP_CLR_IN: begin
							latched_q  <= '0;
							armed_in_q <= '0;
						end
						etl_pkg::OP_UNTIL_TMR: begin
							if (tm_ok) begin
								state_q <= etl_pkg::ST_SCAN_A;
								done_q  <= 1'b0;
							end
						end
						etl_pkg::OP_UNTIL_NEXT: begin
							if (latched_q == '0) begin
								state_q <= etl_pkg::ST_SCAN_A;
								done_q  <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				etl_pkg::ST_SCAN_A: begin
					if (rd_armed && !le_imax) begin
						state_q <= etl_pkg::ST_SCAN_B;
					end else if (scan_end) begin
						state_q <= etl_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				etl_pkg::ST_SCAN_B: begin
					if (scan_end) begin
						state_q <= etl_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= etl_pkg::ST_SCAN_A;
					end
				end
				default: begin
					state_q <= etl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			etl_pkg::ST_IDLE: begin
				if (start) begin
					op_q     <= etl_pkg::op_t'(op);
					idx_q    <= index;
					now_q    <= time_now;
					tmo_q    <= timeout;
					single_q <= (op != etl_pkg::OP_UNTIL_NEXT);
					cnt_q    <= (op == etl_pkg::OP_UNTIL_NEXT) ? '0 : TW'(index);
					min_q    <= etl_pkg::TICK_MAX;
				end
			end
			etl_pkg::ST_EXEC: begin
				hit_q   <= 1'b0;
				value_q <= '0;
				unique case (op_q)
					etl_pkg::OP_CHK_IN: begin
						if ((latched_q & in_bit) != '0) begin
							hit_q   <= 1'b1;
							value_q <= dres;
						end
					end
					etl_pkg::OP_CHK_TMR: begin
						if (tm_ok && rd_armed && lt_imax) begin
							hit_q   <= 1'b1;
							value_q <= dres;
						end
					end
					etl_pkg::OP_UNTIL_TMR: begin
						value_q <= etl_pkg::TICK_MAX;
					end
					default: begin
					end
				endcase
			end
			etl_pkg::ST_SCAN_A: begin
				min_q   <= min_nxt;
				value_q <= min_nxt;
				if (!(rd_armed && !le_imax) && !scan_end) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			etl_pkg::ST_SCAN_B: begin
				min_q   <= min_nxt;
				value_q <= min_nxt;
				if (!scan_end) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy  = (state_q != etl_pkg::ST_IDLE);
	assign done  = done_q;
	assign hit   = hit_q;
	assign value = value_q;

endmodule
